// ===== sv/rpr_pkg.sv =====
// shared types, constants and codes of the rc pulse remap servo generator
package rpr_pkg;

    localparam int COUNTER_BITS_DEF = 16;

    localparam int PULSE_W    = 12;
    localparam int CMD_W      = 12;
    localparam int TIMER_W    = 16;
    localparam int GAP_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [PULSE_W-1:0] RANGE_LO_RST   = 12'd1000;
    localparam logic [PULSE_W-1:0] RANGE_HI_RST   = 12'd2000;
    localparam logic [CMD_W-1:0]   FIRST_MIN_RST  = 12'd1610;
    localparam logic [CMD_W-1:0]   FIRST_MAX_RST  = 12'd1460;
    localparam logic [CMD_W-1:0]   SECOND_MIN_RST = 12'd2000;
    localparam logic [CMD_W-1:0]   SECOND_MAX_RST = 12'd1000;
    localparam logic [TIMER_W-1:0] FRAME_RST      = 16'd20000;
    localparam logic [GAP_W-1:0]   GAP_RST        = 10'd100;
    localparam logic [CMD_W-1:0]   CMD_RST        = 12'd1500;
    localparam logic [TIMER_W-1:0] START_WAIT     = 16'd50;
    localparam logic [TIMER_W-1:0] OVERRUN_WAIT   = 16'd50;
    localparam logic [TIMER_W-1:0] TIMER_SAT      = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_LO          = 3'd0,
        REG_RANGE_HI          = 3'd1,
        REG_FIRST_OUT_AT_MIN  = 3'd2,
        REG_FIRST_OUT_AT_MAX  = 3'd3,
        REG_SECOND_OUT_AT_MIN = 3'd4,
        REG_SECOND_OUT_AT_MAX = 3'd5,
        REG_FRAME_PERIOD      = 3'd6,
        REG_CHANNEL_GAP       = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        PH_WAIT  = 4'b0001,
        PH_HIGH  = 4'b0010,
        PH_GAP   = 4'b0100,
        PH_FRAME = 4'b1000
    } seq_phase_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_PICK   = 8'b0000_0010,
        ST_MUL    = 8'b0000_0100,
        ST_DSTART = 8'b0000_1000,
        ST_DIV    = 8'b0001_0000,
        ST_APPLY  = 8'b0010_0000,
        ST_SEQ    = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } ctrl_state_t;

    typedef struct packed {
        logic rc_level_first;
        logic rc_level_second;
    } in_t;

    typedef struct packed {
        logic             servo_first;
        logic             servo_second;
        logic [CMD_W-1:0] command_first;
        logic [CMD_W-1:0] command_second;
    } out_t;

    typedef struct packed {
        logic accept;
        logic start_map;
        logic map_ch;
        logic mul;
        logic div_start;
        logic apply;
        logic seq;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] pend_cap;
        logic       div_done;
        logic       out_full;
    } dp_status_t;

endpackage

// ===== sv/rc_pulse_remap_servo_generator.sv =====
// top level of the two-channel rc pulse remap and servo pulse generator
// Each request is one 1 us tick carrying two receiver levels; exactly one result
// follows it with both servo drive levels and the current commands. A tick with no
// falling receiver edge goes through the pick, sequencer and done states, the last
// loading the result register, before the next request is taken in idle. Every
// falling edge adds a remap (multiply, divider start, divide, apply) paced by the
// shared restoring divider that yields one quotient bit per clock; with both channels
// falling in the same tick the two remaps run one after the other. A new request is
// taken once the previous one has reached the output register, which waits while an
// earlier result is still untaken. Configuration registers are written through
// cfg_wr_en/cfg_index/cfg_data by the user only while idle; no logic enforces it.
module rc_pulse_remap_servo_generator #(
    parameter int COUNTER_BITS = rpr_pkg::COUNTER_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  rpr_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output rpr_pkg::out_t                  m_data,
    input  logic                           cfg_wr_en,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rpr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rpr_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== sv/rpr_div.sv =====
// restoring unsigned divider, one quotient bit per clock
module rpr_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output logic             busy
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign shifted = {rem_reg, quot_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, den};
    assign fits    = shifted >= {1'b0, den};

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quot_next = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quot_next = {quot_reg[NUM_W-2:0], fits};
            rem_next  = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quot = quot_reg;
    assign busy = busy_reg;

endmodule

// ===== sv/rpr_dp.sv =====
// datapath: config registers, pulse capture, linear remap, servo sequencer, output stage
module rpr_dp #(
    parameter int COUNTER_BITS = rpr_pkg::COUNTER_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rpr_pkg::in_t                    s_data,
    input  logic                            m_ready,
    output rpr_pkg::out_t                   m_data,
    output logic                            m_valid,
    input  logic                            cfg_wr_en,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  rpr_pkg::dp_cmd_t                cmd,
    output rpr_pkg::dp_status_t             status
);
    import rpr_pkg::*;

    localparam int MAG_W = COUNTER_BITS + PULSE_W;
    localparam int VAL_W = MAG_W + 2;

    // configuration
    logic [PULSE_W-1:0] range_lo_reg, range_hi_reg;
    logic [CMD_W-1:0]   out_min_reg [2];
    logic [CMD_W-1:0]   out_max_reg [2];
    logic [TIMER_W-1:0] frame_period_reg;
    logic [GAP_W-1:0]   channel_gap_reg;

    // capture and commands
    logic [1:0]              prev_reg, prev_next;
    logic [1:0]              pend_reg, pend_next;
    logic [COUNTER_BITS-1:0] cnt_reg [2];
    logic [COUNTER_BITS-1:0] cnt_next [2];
    logic [CMD_W-1:0]        cmd_reg [2];
    logic [CMD_W-1:0]        cmd_next [2];
    logic                    ch_sel_reg, ch_sel_next;

    // sequencer
    seq_phase_t         phase_reg, phase_next;
    logic               chan_reg, chan_next;
    logic [TIMER_W-1:0] pt_reg, pt_next;
    logic [TIMER_W-1:0] ft_reg, ft_next;
    logic               servo0_reg, servo0_next;
    logic               servo1_reg, servo1_next;

    // remap operands
    logic [MAG_W-1:0] num_mag_reg, num_mag_next;
    logic [PULSE_W-1:0] den_mag_reg, den_mag_next;
    logic             q_neg_reg, q_neg_next;
    logic             den_zero_reg, den_zero_next;

    out_t m_data_reg, m_data_next;
    logic m_valid_reg, m_valid_next;

    logic [1:0]              lvl;
    logic [COUNTER_BITS-1:0] width;
    logic [COUNTER_BITS-1:0] lo_wide;
    logic [COUNTER_BITS-1:0] diff_mag;
    logic                    diff_neg;
    logic [CMD_W-1:0]        span_mag;
    logic                    span_neg;
    logic [PULSE_W-1:0]      den_mag;
    logic                    den_neg;
    logic [MAG_W-1:0]        prod;
    logic [MAG_W-1:0]        div_quot;
    logic                    div_busy;

    logic signed [VAL_W-1:0] q_ext, q_signed, omin_ext, lo_ext, hi_ext, val;
    logic                    val_ok;

    assign lvl = {s_data.rc_level_second, s_data.rc_level_first};

    // width minus min, output span and input span as sign and magnitude
    assign width    = cnt_reg[ch_sel_reg];
    assign lo_wide  = COUNTER_BITS'(range_lo_reg);
    assign diff_neg = width < lo_wide;
    assign diff_mag = diff_neg ? lo_wide - width : width - lo_wide;
    assign span_neg = out_max_reg[ch_sel_reg] < out_min_reg[ch_sel_reg];
    assign span_mag = span_neg ? out_min_reg[ch_sel_reg] - out_max_reg[ch_sel_reg]
                               : out_max_reg[ch_sel_reg] - out_min_reg[ch_sel_reg];
    assign den_neg  = range_hi_reg < range_lo_reg;
    assign den_mag  = den_neg ? range_lo_reg - range_hi_reg
                              : range_hi_reg - range_lo_reg;
    assign prod     = MAG_W'(diff_mag) * MAG_W'(span_mag);

    rpr_div #(
        .NUM_W (MAG_W),
        .DEN_W (PULSE_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_mag_reg),
        .den     (den_mag_reg),
        .quot    (div_quot),
        .busy    (div_busy)
    );

    // quotient truncates toward zero, sign applied afterwards
    assign q_ext    = VAL_W'(div_quot);
    assign q_signed = q_neg_reg ? -q_ext : q_ext;
    assign omin_ext = VAL_W'(out_min_reg[ch_sel_reg]);
    assign lo_ext   = VAL_W'(range_lo_reg);
    assign hi_ext   = VAL_W'(range_hi_reg);
    assign val      = den_zero_reg ? omin_ext : q_signed + omin_ext;
    assign val_ok   = (val >= lo_ext) && (val <= hi_ext);

    always_comb begin
        logic [TIMER_W-1:0] ft_inc;
        logic [TIMER_W-1:0] pt_dec;
        logic [CMD_W-1:0]   cmd_cur;

        prev_next     = prev_reg;
        pend_next     = pend_reg;
        cnt_next      = cnt_reg;
        cmd_next      = cmd_reg;
        ch_sel_next   = ch_sel_reg;
        phase_next    = phase_reg;
        chan_next     = chan_reg;
        pt_next       = pt_reg;
        ft_next       = ft_reg;
        servo0_next   = servo0_reg;
        servo1_next   = servo1_reg;
        num_mag_next  = num_mag_reg;
        den_mag_next  = den_mag_reg;
        q_neg_next    = q_neg_reg;
        den_zero_next = den_zero_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;

        ft_inc  = (ft_reg != TIMER_SAT) ? ft_reg + TIMER_W'(1) : ft_reg;
        pt_dec  = (pt_reg != '0) ? pt_reg - TIMER_W'(1) : pt_reg;
        cmd_cur = cmd_reg[chan_reg];

        if (cmd.accept) begin
            for (int i = 0; i < 2; i++) begin
                if (lvl[i]) begin
                    if (!prev_reg[i]) begin
                        cnt_next[i] = COUNTER_BITS'(1);
                    end else if (cnt_reg[i] != {COUNTER_BITS{1'b1}}) begin
                        cnt_next[i] = cnt_reg[i] + COUNTER_BITS'(1);
                    end
                end
            end
            // falling edge latches the width for remapping
            pend_next = prev_reg & ~lvl;
            prev_next = lvl;
        end

        if (cmd.start_map) begin
            ch_sel_next          = cmd.map_ch;
            pend_next[cmd.map_ch] = 1'b0;
        end

        if (cmd.mul) begin
            num_mag_next  = prod;
            den_mag_next  = den_mag;
            q_neg_next    = diff_neg ^ span_neg ^ den_neg;
            den_zero_next = den_mag == '0;
        end

        if (cmd.apply && val_ok) begin
            cmd_next[ch_sel_reg] = val[CMD_W-1:0];
        end

        if (cmd.seq) begin
            servo0_next = (phase_reg == PH_HIGH) && !chan_reg;
            servo1_next = (phase_reg == PH_HIGH) && chan_reg;
            ft_next     = ft_inc;
            pt_next     = pt_dec;
            if (pt_dec == '0) begin
                if (phase_reg == PH_HIGH) begin
                    chan_next = ~chan_reg;
                    if (!chan_reg) begin
                        phase_next = PH_GAP;
                        pt_next    = (channel_gap_reg == '0) ? TIMER_W'(1)
                                                             : TIMER_W'(channel_gap_reg);
                    end else begin
                        phase_next = PH_FRAME;
                        // frame already overran: short restart wait
                        pt_next    = (ft_inc < frame_period_reg) ? frame_period_reg - ft_inc
                                                                 : OVERRUN_WAIT;
                    end
                end else begin
                    phase_next = PH_HIGH;
                    pt_next    = (cmd_cur == '0) ? TIMER_W'(1) : TIMER_W'(cmd_cur);
                    if (!chan_reg) begin
                        ft_next = '0;
                    end
                end
            end
        end

        if (cmd.load_out) begin
            m_data_next.servo_first    = servo0_reg;
            m_data_next.servo_second   = servo1_reg;
            m_data_next.command_first  = cmd_reg[0];
            m_data_next.command_second = cmd_reg[1];
            m_valid_next               = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_lo_reg     <= RANGE_LO_RST;
            range_hi_reg     <= RANGE_HI_RST;
            out_min_reg[0]   <= FIRST_MIN_RST;
            out_max_reg[0]   <= FIRST_MAX_RST;
            out_min_reg[1]   <= SECOND_MIN_RST;
            out_max_reg[1]   <= SECOND_MAX_RST;
            frame_period_reg <= FRAME_RST;
            channel_gap_reg  <= GAP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RANGE_LO:          range_lo_reg     <= cfg_data[PULSE_W-1:0];
                REG_RANGE_HI:          range_hi_reg     <= cfg_data[PULSE_W-1:0];
                REG_FIRST_OUT_AT_MIN:  out_min_reg[0]   <= cfg_data[CMD_W-1:0];
                REG_FIRST_OUT_AT_MAX:  out_max_reg[0]   <= cfg_data[CMD_W-1:0];
                REG_SECOND_OUT_AT_MIN: out_min_reg[1]   <= cfg_data[CMD_W-1:0];
                REG_SECOND_OUT_AT_MAX: out_max_reg[1]   <= cfg_data[CMD_W-1:0];
                REG_FRAME_PERIOD:      frame_period_reg <= cfg_data[TIMER_W-1:0];
                REG_CHANNEL_GAP:       channel_gap_reg  <= cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            pend_reg    <= '0;
            cnt_reg[0]  <= '0;
            cnt_reg[1]  <= '0;
            cmd_reg[0]  <= CMD_RST;
            cmd_reg[1]  <= CMD_RST;
            ch_sel_reg  <= 1'b0;
            phase_reg   <= PH_WAIT;
            chan_reg    <= 1'b0;
            pt_reg      <= START_WAIT;
            ft_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            prev_reg    <= prev_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
            cmd_reg     <= cmd_next;
            ch_sel_reg  <= ch_sel_next;
            phase_reg   <= phase_next;
            chan_reg    <= chan_next;
            pt_reg      <= pt_next;
            ft_reg      <= ft_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        servo0_reg   <= servo0_next;
        servo1_reg   <= servo1_next;
        num_mag_reg  <= num_mag_next;
        den_mag_reg  <= den_mag_next;
        q_neg_reg    <= q_neg_next;
        den_zero_reg <= den_zero_next;
        m_data_reg   <= m_data_next;
    end

    assign m_data          = m_data_reg;
    assign m_valid         = m_valid_reg;
    assign status.pend_cap = pend_reg;
    assign status.div_done = !div_busy;
    assign status.out_full = m_valid_reg;

endmodule

// ===== sv/rpr_ctrl.sv =====
// controller: steps each request through capture, remap, sequencer and output
module rpr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 m_ready,
    input  rpr_pkg::dp_status_t  status,
    output rpr_pkg::dp_cmd_t     cmd
);
    import rpr_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                priority if (status.pend_cap[0]) begin
                    cmd.start_map = 1'b1;
                    cmd.map_ch    = 1'b0;
                    state_next    = ST_MUL;
                end else if (status.pend_cap[1]) begin
                    cmd.start_map = 1'b1;
                    cmd.map_ch    = 1'b1;
                    state_next    = ST_MUL;
                end else begin
                    state_next = ST_SEQ;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DSTART;
            end
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_PICK;
            end
            ST_SEQ: begin
                cmd.seq    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait for the output stage to free up
                if (!status.out_full || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_PICK))
        else $error("request accepted but controller did not move to capture handling");

    a_load_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!status.out_full || m_ready))
        else $error("result loaded over an untaken result");

    a_no_pending_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (status.pend_cap == 2'b00))
        else $error("capture left unmapped at end of request");

    a_div_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> status.div_done)
        else $error("divider restarted while busy");

endmodule
